[rtl/core/ofwm_pkg.sv]
// ----------------------------------------------------------------------------
// ofwm_pkg
// types, constants and the sine series for the four wheel omni mixer
// ----------------------------------------------------------------------------
package ofwm_pkg;

  localparam int POWER_BITS = 16;
  localparam int ANGLE_BITS = 16;
  localparam int LIMIT_BITS = POWER_BITS - 1;
  localparam logic [LIMIT_BITS-1:0] FULL_SCALE = '1;
  localparam int SINE_BITS = 31;
  localparam longint Q30_ONE = longint'(1) <<< 30;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;

  typedef enum logic {
    REG_LINEAR_LIMIT  = 1'b0,
    REG_ANGULAR_LIMIT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic signed [POWER_BITS-1:0] linear_cmd;
    logic        [ANGLE_BITS-1:0] heading;
    logic signed [POWER_BITS-1:0] rotation_cmd;
  } cmd_t;

  typedef struct packed {
    logic signed [POWER_BITS-1:0] front_left_power;
    logic signed [POWER_BITS-1:0] back_left_power;
    logic signed [POWER_BITS-1:0] back_right_power;
    logic signed [POWER_BITS-1:0] front_right_power;
  } wheel_t;

  // quarter wave sine entry in q30, integer horner series
  function automatic logic [SINE_BITS-1:0] make_sine(int unsigned k, int unsigned tb);
    longint x;
    longint x2;
    longint t;
    x  = (longint'(k) * HALF_PI_Q30 + (longint'(1) <<< (tb - 3))) >>> (tb - 2);
    x2 = (x * x) >>> 30;
    t  = Q30_ONE;
    t  = Q30_ONE - ((x2 * t) >>> 30) / 156;
    t  = Q30_ONE - ((x2 * t) >>> 30) / 110;
    t  = Q30_ONE - ((x2 * t) >>> 30) / 72;
    t  = Q30_ONE - ((x2 * t) >>> 30) / 42;
    t  = Q30_ONE - ((x2 * t) >>> 30) / 20;
    t  = Q30_ONE - ((x2 * t) >>> 30) / 6;
    t  = (x * t) >>> 30;
    if (t < 0) t = 0;
    if (t > Q30_ONE) t = Q30_ONE;
    return t[SINE_BITS-1:0];
  endfunction

endpackage

[rtl/core/omni_four_wheel_mixer_top.sv]
// ----------------------------------------------------------------------------
// omni_four_wheel_mixer_top
// throughput: one request per cycle, every stage is pipelined, including the
// one-bit-per-stage split dividers
// the whole pipeline holds while a result waits on out_stall
// reset (rst_n low, synchronous) empties the pipeline and sets both limits
// to full scale
// ----------------------------------------------------------------------------
module omni_four_wheel_mixer_top #(
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  ofwm_pkg::cmd_t                 in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output ofwm_pkg::wheel_t               out_data,
  input  logic                           cfg_we,
  input  ofwm_pkg::cfg_reg_t             cfg_index,
  input  logic [ofwm_pkg::LIMIT_BITS-1:0] cfg_wdata
);

  localparam int P   = ofwm_pkg::POWER_BITS;
  localparam int AB  = ofwm_pkg::ANGLE_BITS;
  localparam int LB  = ofwm_pkg::LIMIT_BITS;
  localparam int SB  = ofwm_pkg::SINE_BITS;
  localparam int TB  = SINE_TABLE_BITS;
  localparam int QS  = 1 << (TB - 2);
  localparam int IW  = TB - 1;           // table index width, QS+1 entries
  localparam int QW  = P - 1;            // quotient bits of the split dividers
  localparam int NA  = 2 * P - 1;        // scale numerator
  localparam int NB  = P + 31;           // split divider numerator
  localparam int CW  = 32;               // signed sine / cosine width
  localparam int TA  = 1 + P + 3 * CW;   // sideband through the scale stage
  localparam int VD  = QW + 4;           // valid stages before output reg
  localparam logic signed [P-1:0] FS_S = {1'b0, ofwm_pkg::FULL_SCALE};

  // the pipeline moves unless a finished result sits unaccepted
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // limit registers
  logic [LB-1:0] lin_lim_r, ang_lim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lin_lim_r <= ofwm_pkg::FULL_SCALE;
      ang_lim_r <= ofwm_pkg::FULL_SCALE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ofwm_pkg::REG_LINEAR_LIMIT:  lin_lim_r <= cfg_wdata;
        ofwm_pkg::REG_ANGULAR_LIMIT: ang_lim_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // valid bits travel alongside the data stages
  logic [VD-1:0] vld_r;
  logic          out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[VD-2:0], in_valid && !in_stall};
      out_valid_r <= vld_r[VD-1];
    end
  end
  assign out_valid = out_valid_r;

  // quarter wave sine table, built at elaboration
  logic [SB-1:0] sine_lut [QS+1];
  for (genvar k = 0; k <= QS; k++) begin : g_lut
    assign sine_lut[k] = ofwm_pkg::make_sine(k, TB);
  end

  // ---------------- stage 1: clamp and table lookup ----------------
  logic [TB-1:0] idx_s, idx_c;
  if (AB >= TB) begin : g_idx_trunc
    assign idx_s = in_data.heading[AB-1 -: TB];
  end else begin : g_idx_ext
    assign idx_s = {in_data.heading, {(TB - AB){1'b0}}};
  end
  assign idx_c = idx_s + TB'(QS);

  logic signed [P-1:0]  lin_nxt, rot_nxt, lin_lim_s, ang_lim_s;
  logic signed [CW-1:0] sn_nxt, c_nxt;
  logic [IW-1:0]        ls, lc;

  always_comb begin
    lin_lim_s = {1'b0, lin_lim_r};
    ang_lim_s = {1'b0, ang_lim_r};
    lin_nxt   = in_data.linear_cmd;
    if (in_data.linear_cmd > lin_lim_s) lin_nxt = lin_lim_s;
    else if (in_data.linear_cmd < -lin_lim_s) lin_nxt = -lin_lim_s;
    rot_nxt   = in_data.rotation_cmd;
    if (in_data.rotation_cmd > ang_lim_s) rot_nxt = ang_lim_s;
    else if (in_data.rotation_cmd < -ang_lim_s) rot_nxt = -ang_lim_s;
    // odd quadrants read the table mirrored, the upper half is negated
    ls = idx_s[TB-2] ? (IW'(QS) - {1'b0, idx_s[TB-3:0]}) : {1'b0, idx_s[TB-3:0]};
    lc = idx_c[TB-2] ? (IW'(QS) - {1'b0, idx_c[TB-3:0]}) : {1'b0, idx_c[TB-3:0]};
    sn_nxt = CW'(signed'({1'b0, sine_lut[ls]}));
    c_nxt  = CW'(signed'({1'b0, sine_lut[lc]}));
    if (idx_s[TB-1]) sn_nxt = -sn_nxt;
    if (idx_c[TB-1]) c_nxt  = -c_nxt;
  end

  logic signed [P-1:0]  lin1_r, rot1_r;
  logic signed [CW-1:0] sn1_r, c1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      lin1_r <= lin_nxt;
      rot1_r <= rot_nxt;
      sn1_r  <= sn_nxt;
      c1_r   <= c_nxt;
    end
  end

  // ---------------- stage 2: rotation headroom product and denominator ------
  logic signed [P-1:0]   arot1;
  logic signed [P:0]     head1;
  logic signed [2*P:0]   p_nxt;
  logic [CW-1:0]         den_nxt;

  always_comb begin
    arot1   = rot1_r[P-1] ? -rot1_r : rot1_r;
    head1   = {2'b00, ofwm_pkg::FULL_SCALE} - {arot1[P-1], arot1};
    p_nxt   = lin1_r * head1;
    den_nxt = CW'(c1_r[CW-1] ? -c1_r : c1_r) + CW'(sn1_r[CW-1] ? -sn1_r : sn1_r);
  end

  logic signed [2*P:0]  p2_r;
  logic [CW-1:0]        den2_r;
  logic signed [P-1:0]  rot2_r;
  logic signed [CW-1:0] sn2_r, c2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p2_r   <= p_nxt;
      den2_r <= den_nxt;
      rot2_r <= rot1_r;
      sn2_r  <= sn1_r;
      c2_r   <= c1_r;
    end
  end

  // ---------------- scale stage: s = round(p / full scale) ----------------
  // full scale is 2^(P-1)-1, so the high part folds back onto the low part
  // twice and one compare against full scale finishes the quotient
  logic signed [2*P:0] pabs2;
  logic [NA-1:0]       num_a;
  logic [TA-1:0]       tag_a_in;
  logic [P-1:0]        hi_a;
  logic [P:0]          fold_a;
  logic [LB:0]         rem_a;
  logic [P:0]          qsum_a;

  assign pabs2    = p2_r[2*P] ? -p2_r : p2_r;
  assign num_a    = NA'(pabs2) + NA'(ofwm_pkg::FULL_SCALE >> 1);
  assign tag_a_in = {p2_r[2*P], rot2_r, c2_r, sn2_r, den2_r};
  assign hi_a     = num_a[NA-1:LB];
  assign fold_a   = {1'b0, hi_a} + (P + 1)'(num_a[LB-1:0]);
  assign rem_a    = (LB + 1)'(fold_a[P:LB]) + (LB + 1)'(fold_a[LB-1:0]);
  assign qsum_a   = {1'b0, hi_a} + (P + 1)'(fold_a[P:LB])
                  + (P + 1)'(rem_a >= {1'b0, ofwm_pkg::FULL_SCALE});

  logic [QW-1:0] quo_a_r;
  logic [TA-1:0] tag_a_r;

  always_ff @(posedge clk) begin
    if (en) begin
      quo_a_r <= qsum_a[QW-1:0];
      tag_a_r <= tag_a_in;
    end
  end

  // ---------------- stage 3: split products ----------------
  logic                 neg_a;
  logic signed [P-1:0]  rot_a, s_a;
  logic signed [CW-1:0] c_a, sn_a;
  logic [CW-1:0]        den_a;

  always_comb begin
    {neg_a, rot_a, c_a, sn_a, den_a} = tag_a_r;
    s_a = neg_a ? -signed'({1'b0, quo_a_r}) : signed'({1'b0, quo_a_r});
  end

  logic signed [P+CW-1:0] pc3_r, ps3_r;
  logic [CW-1:0]          den3_r;
  logic signed [P-1:0]    rot3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pc3_r  <= s_a * c_a;
      ps3_r  <= s_a * sn_a;
      den3_r <= (den_a == '0) ? CW'(1) : den_a;
      rot3_r <= rot_a;
    end
  end

  // ---------------- split dividers: lon and lat ----------------
  logic signed [P+CW-1:0] pcabs, psabs;
  logic [NB-1:0]          num_lon, num_lat;
  logic [QW-1:0]          quo_lon, quo_lat;
  logic [P:0]             tag_lon;
  logic                   neg_lat;

  assign pcabs   = pc3_r[P+CW-1] ? -pc3_r : pc3_r;
  assign psabs   = ps3_r[P+CW-1] ? -ps3_r : ps3_r;
  assign num_lon = NB'(pcabs) + NB'(den3_r >> 1);
  assign num_lat = NB'(psabs) + NB'(den3_r >> 1);

  ofwm_div #(.NW(NB), .DW(CW), .QW(QW), .TW(P + 1)) u_div_lon (
    .clk     (clk),
    .en      (en),
    .in_num  (num_lon),
    .in_den  (den3_r),
    .in_tag  ({pc3_r[P+CW-1], rot3_r}),
    .out_quo (quo_lon),
    .out_tag (tag_lon)
  );

  ofwm_div #(.NW(NB), .DW(CW), .QW(QW), .TW(1)) u_div_lat (
    .clk     (clk),
    .en      (en),
    .in_num  (num_lat),
    .in_den  (den3_r),
    .in_tag  (ps3_r[P+CW-1]),
    .out_quo (quo_lat),
    .out_tag (neg_lat)
  );

  // ---------------- output: wheel sums, saturation ----------------
  function automatic logic signed [P-1:0] sat(input logic signed [P+1:0] v);
    logic signed [P+1:0] fs;
    fs = (P + 2)'(FS_S);
    if (v > fs) return FS_S;
    if (v < -fs) return -FS_S;
    return v[P-1:0];
  endfunction

  logic signed [P+1:0] lon, lat, rot;
  ofwm_pkg::wheel_t    wheel_nxt, out_data_r;

  always_comb begin
    lon = (P + 2)'(signed'({1'b0, quo_lon}));
    lat = (P + 2)'(signed'({1'b0, quo_lat}));
    if (tag_lon[P]) lon = -lon;
    if (neg_lat) lat = -lat;
    rot = (P + 2)'(signed'(tag_lon[P-1:0]));
    wheel_nxt.front_left_power  = sat(-lon + lat + rot);
    wheel_nxt.back_left_power   = sat(-lon - lat + rot);
    wheel_nxt.back_right_power  = sat(lon - lat + rot);
    wheel_nxt.front_right_power = sat(lon + lat + rot);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= wheel_nxt;
    end
  end
  assign out_data = out_data_r;

endmodule

[rtl/core/ofwm_div.sv]
// ----------------------------------------------------------------------------
// ofwm_div
// pipelined restoring divider, one quotient bit per stage, with sideband
// ----------------------------------------------------------------------------
module ofwm_div #(
  parameter int NW = 31,
  parameter int DW = 15,
  parameter int QW = 15,
  parameter int TW = 1
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [TW-1:0] in_tag,
  output logic [QW-1:0] out_quo,
  output logic [TW-1:0] out_tag
);

  localparam int SW = NW + DW;

  logic [NW-1:0] rem_r [QW];
  logic [DW-1:0] den_r [QW];
  logic [QW-1:0] quo_r [QW];
  logic [TW-1:0] tag_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [NW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] quo_in;
    logic [TW-1:0] tag_in;
    logic [SW-1:0] dsh;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_in = in_num;
      assign den_in = in_den;
      assign quo_in = '0;
      assign tag_in = in_tag;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
      assign quo_in = quo_r[k-1];
      assign tag_in = tag_r[k-1];
    end

    assign dsh = {{NW{1'b0}}, den_in} << (QW - 1 - k);
    assign ge  = {{DW{1'b0}}, rem_in} >= dsh;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? (rem_in - dsh[NW-1:0]) : rem_in;
        den_r[k] <= den_in;
        quo_r[k] <= quo_in | (ge ? (QW'(1) << (QW - 1 - k)) : '0);
        tag_r[k] <= tag_in;
      end
    end
  end

  assign out_quo = quo_r[QW-1];
  assign out_tag = tag_r[QW-1];

endmodule

[tb/sv/tb_omni_four_wheel_mixer_top.sv]
// ----------------------------------------------------------------------------
// tb_omni_four_wheel_mixer_top
// drive commands into the four wheel omni mixer under random idling on both
// sides, predict the wheel powers from a local fixed point model of the
// kinematics and compare every result in order, over several limit settings
// ----------------------------------------------------------------------------
module tb_omni_four_wheel_mixer_top;

  localparam int TABLE_BITS = 10;
  localparam int QSTEPS = 1 << (TABLE_BITS - 2);
  localparam longint FS = (longint'(1) << (ofwm_pkg::POWER_BITS - 1)) - 1;
  localparam int LATENCY = (ofwm_pkg::POWER_BITS - 1) + 5;
  localparam int WATCHDOG_LIMIT = 20000;

  // scoreboard: quarter sine, limits and the queue of predicted wheel powers
  class wheel_scoreboard;
    longint quarter_sine[QSTEPS + 1];
    longint lin_limit;
    longint rot_limit;
    ofwm_pkg::wheel_t pending[$];
    int errors;

    function new();
      longint x, x2, t;
      longint divs[6];
      divs = '{156, 110, 72, 42, 20, 6};
      for (int k = 0; k <= QSTEPS; k++) begin
        x = (longint'(k) * ofwm_pkg::HALF_PI_Q30 + QSTEPS / 2) / QSTEPS;
        x2 = (x * x) >>> 30;
        t = ofwm_pkg::Q30_ONE;
        for (int i = 0; i < 6; i++) begin
          t = ofwm_pkg::Q30_ONE - ((x2 * t) >>> 30) / divs[i];
        end
        t = (x * t) >>> 30;
        if (t < 0) t = 0;
        if (t > ofwm_pkg::Q30_ONE) t = ofwm_pkg::Q30_ONE;
        quarter_sine[k] = t;
      end
      lin_limit = FS;
      rot_limit = FS;
      errors = 0;
    endfunction

    function longint sine_of(int unsigned idx);
      int unsigned i, quad, r;
      longint v;
      i = idx % (1 << TABLE_BITS);
      quad = i / QSTEPS;
      r = i % QSTEPS;
      v = quad[0] ? quarter_sine[QSTEPS - r] : quarter_sine[r];
      return quad[1] ? -v : v;
    endfunction

    // divide with rounding to nearest, ties away from zero
    function longint round_div(longint n, longint d);
      longint m;
      m = n < 0 ? -n : n;
      m = (m + d / 2) / d;
      return n < 0 ? -m : m;
    endfunction

    function longint clamp(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
    endfunction

    function void set_limit(ofwm_pkg::cfg_reg_t idx, longint value);
      if (idx == ofwm_pkg::REG_LINEAR_LIMIT) lin_limit = value;
      else rot_limit = value;
    endfunction

    function void note_command(ofwm_pkg::cmd_t c);
      longint lin, rot, sn, cs, den, s, lon, lat;
      int unsigned idx;
      ofwm_pkg::wheel_t w;
      lin = clamp(longint'(c.linear_cmd), lin_limit);
      rot = clamp(longint'(c.rotation_cmd), rot_limit);
      idx = c.heading >> (ofwm_pkg::ANGLE_BITS - TABLE_BITS);
      sn = sine_of(idx);
      cs = sine_of(idx + QSTEPS);
      den = (cs < 0 ? -cs : cs) + (sn < 0 ? -sn : sn);
      if (den <= 0) den = 1;
      s = round_div(lin * (FS - (rot < 0 ? -rot : rot)), FS);
      lon = round_div(s * cs, den);
      lat = round_div(s * sn, den);
      w.front_left_power  = ofwm_pkg::POWER_BITS'(clamp(-lon + lat + rot, FS));
      w.back_left_power   = ofwm_pkg::POWER_BITS'(clamp(-lon - lat + rot, FS));
      w.back_right_power  = ofwm_pkg::POWER_BITS'(clamp(lon - lat + rot, FS));
      w.front_right_power = ofwm_pkg::POWER_BITS'(clamp(lon + lat + rot, FS));
      pending.push_back(w);
    endfunction

    function void check_wheels(ofwm_pkg::wheel_t got);
      ofwm_pkg::wheel_t exp_w;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, got);
        errors++;
        return;
      end
      exp_w = pending.pop_front();
      if (got.front_left_power !== exp_w.front_left_power) begin
        $display("%0t: front_left expected %0d got %0d", $realtime,
                 exp_w.front_left_power, got.front_left_power);
        errors++;
      end
      if (got.back_left_power !== exp_w.back_left_power) begin
        $display("%0t: back_left expected %0d got %0d", $realtime,
                 exp_w.back_left_power, got.back_left_power);
        errors++;
      end
      if (got.back_right_power !== exp_w.back_right_power) begin
        $display("%0t: back_right expected %0d got %0d", $realtime,
                 exp_w.back_right_power, got.back_right_power);
        errors++;
      end
      if (got.front_right_power !== exp_w.front_right_power) begin
        $display("%0t: front_right expected %0d got %0d", $realtime,
                 exp_w.front_right_power, got.front_right_power);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  ofwm_pkg::cmd_t in_data;
  logic out_valid;
  logic out_stall;
  ofwm_pkg::wheel_t out_data;
  logic cfg_we;
  ofwm_pkg::cfg_reg_t cfg_index;
  logic [ofwm_pkg::LIMIT_BITS-1:0] cfg_wdata;

  wheel_scoreboard board;
  int idle_cycles;
  bit stall_enable;

  omni_four_wheel_mixer_top #(.SINE_TABLE_BITS(TABLE_BITS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // gap length: mostly short, now and then long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result side: check accepted results, stall at random
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) board.check_wheels(out_data);
      if (!stall_enable) out_stall <= 1'b0;
      else out_stall <= (gap_len() != 0);
    end
  end

  // watchdog on cycles with no request or result moving
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[omni_four_wheel_mixer_top] ERROR");
        $finish;
      end
    end
  end

  // send one request, waiting out the handshake, with an optional gap first
  task automatic send_cmd(ofwm_pkg::cmd_t c, bit with_gap);
    int gap;
    gap = with_gap ? gap_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_command(c);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // limit writes only with the pipeline empty
  task automatic write_limit(ofwm_pkg::cfg_reg_t idx,
                             logic [ofwm_pkg::LIMIT_BITS-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_limit(idx, longint'(value));
  endtask

  function automatic logic signed [ofwm_pkg::POWER_BITS-1:0] rand_power();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'sh8000;
    if (r == 1) return 16'sh7fff;
    if (r == 2) return 16'sh8001;
    if (r == 3) return 16'sh0000;
    return ofwm_pkg::POWER_BITS'($urandom);
  endfunction

  task automatic random_phase(int count, bit pause_midway);
    ofwm_pkg::cmd_t c;
    for (int i = 0; i < count; i++) begin
      c.linear_cmd = rand_power();
      c.heading = ($urandom_range(0, 3) == 0) ?
                  16'(($urandom_range(0, 7)) << 13) : 16'($urandom);
      c.rotation_cmd = ($urandom_range(0, 2) == 0) ? 16'sh0000 : rand_power();
      // some stretches with no idling on the request side
      send_cmd(c, (i % 100) >= 30);
      // sender holds off until every result has arrived
      if (pause_midway && i == count / 2) drain();
    end
  endtask

  initial begin
    ofwm_pkg::cmd_t c;
    logic signed [ofwm_pkg::POWER_BITS-1:0] pw[6];
    logic [ofwm_pkg::ANGLE_BITS-1:0] hd[6];
    board = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = ofwm_pkg::REG_LINEAR_LIMIT;
    cfg_wdata = '0;
    stall_enable = 1'b0;
    idle_cycles = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes of power, the quadrant headings, most negative code
    pw = '{16'sh7fff, 16'sh8001, 16'sh8000, 16'sh0000, 16'sh0001, 16'shffff};
    hd = '{16'h0000, 16'h4000, 16'h8000, 16'hc000, 16'h2000, 16'hffff};
    for (int i = 0; i < 6; i++) begin
      c.linear_cmd = pw[i];
      c.heading = hd[i];
      c.rotation_cmd = pw[(i + 3) % 6];
      send_cmd(c, 1'b0);
      c.rotation_cmd = pw[i];
      c.heading = ~hd[i];
      send_cmd(c, 1'b0);
    end
    drain();
    stall_enable = 1'b1;

    // default limits first
    random_phase(300, 1'b1);
    drain();

    // zero limits force the powers to zero
    write_limit(ofwm_pkg::REG_LINEAR_LIMIT, '0);
    write_limit(ofwm_pkg::REG_ANGULAR_LIMIT, '0);
    random_phase(100, 1'b0);
    drain();

    write_limit(ofwm_pkg::REG_LINEAR_LIMIT, ofwm_pkg::LIMIT_BITS'(16384));
    write_limit(ofwm_pkg::REG_ANGULAR_LIMIT, ofwm_pkg::LIMIT_BITS'(1));
    random_phase(250, 1'b0);
    drain();

    write_limit(ofwm_pkg::REG_LINEAR_LIMIT, ofwm_pkg::LIMIT_BITS'($urandom));
    write_limit(ofwm_pkg::REG_ANGULAR_LIMIT, ofwm_pkg::LIMIT_BITS'($urandom));
    random_phase(250, 1'b0);
    drain();

    write_limit(ofwm_pkg::REG_LINEAR_LIMIT, ofwm_pkg::FULL_SCALE);
    write_limit(ofwm_pkg::REG_ANGULAR_LIMIT, ofwm_pkg::FULL_SCALE);
    random_phase(350, 1'b0);
    drain();

    repeat (LATENCY + 8) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("[omni_four_wheel_mixer_top] OK");
    end else begin
      $display("[omni_four_wheel_mixer_top] ERROR");
    end
    $finish;
  end

endmodule
